[hdl/rhcp_pkg.sv]
`default_nettype none
package rhcp_pkg;

	// input operation codes
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_LOAD = 2'd2;

	// parser steps
	localparam logic [4:0] PS_SEARCH  = 5'd0;
	localparam logic [4:0] PS_COMMAND = 5'd1;
	localparam logic [4:0] PS_RED_H   = 5'd2;
	localparam logic [4:0] PS_RED_L   = 5'd3;
	localparam logic [4:0] PS_GREEN_H = 5'd4;
	localparam logic [4:0] PS_GREEN_L = 5'd5;
	localparam logic [4:0] PS_BLUE_H  = 5'd6;
	localparam logic [4:0] PS_BLUE_L  = 5'd7;
	localparam logic [4:0] PS_ADDR_H  = 5'd8;
	localparam logic [4:0] PS_ADDR_L  = 5'd9;
	localparam logic [4:0] PS_END_W   = 5'd10;
	localparam logic [4:0] PS_STUFF_0 = 5'd11;
	localparam logic [4:0] PS_STUFF_1 = 5'd12;
	localparam logic [4:0] PS_STUFF_2 = 5'd13;
	localparam logic [4:0] PS_STUFF_3 = 5'd14;
	localparam logic [4:0] PS_TYPE_H  = 5'd15;
	localparam logic [4:0] PS_TYPE_L  = 5'd16;
	localparam logic [4:0] PS_NEW_H   = 5'd17;
	localparam logic [4:0] PS_NEW_L   = 5'd18;
	localparam logic [4:0] PS_END_I   = 5'd19;

	// button debounce steps
	localparam logic [1:0] BT_RELEASED     = 2'd0;
	localparam logic [1:0] BT_PRESS_SEEN   = 2'd1;
	localparam logic [1:0] BT_PRESSED      = 2'd2;
	localparam logic [1:0] BT_RELEASE_SEEN = 2'd3;

	// command characters
	localparam logic [7:0] CH_PREFIX = 8'h70; // p
	localparam logic [7:0] CH_WRITE  = 8'h77; // w
	localparam logic [7:0] CH_ID     = 8'h69; // i
	localparam logic [7:0] CH_END    = 8'h6F; // o

	// reset values
	localparam logic [7:0] OWN_ADDR_RESET = 8'hFF;
	localparam logic [7:0] RED_RESET      = 8'd128;
	localparam logic [7:0] GREEN_RESET    = 8'd50;
	localparam logic [7:0] BLUE_RESET     = 8'd100;
	localparam logic [7:0] LEVEL_FULL     = 8'hFF;

	typedef struct packed {
		logic [4:0] parse_state;
		logic [7:0] red_stage;
		logic [7:0] green_stage;
		logic [7:0] blue_stage;
		logic [7:0] address_stage;
		logic [7:0] own_address;
		logic       prog_mode;
		logic [1:0] button_state;
		logic [7:0] red_shown;
		logic [7:0] green_shown;
		logic [7:0] blue_shown;
	} lamp_state_t;

	typedef struct packed {
		logic colour_update;
		logic addr_store;
	} lamp_flags_t;

	// case-insensitive hex digit, anything else is 0
	function automatic logic [3:0] hex_value(input logic [7:0] ch);
		logic [3:0] v;
		v = 4'd0;
		if (ch >= 8'h30 && ch <= 8'h39)
			v = ch[3:0];
		else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
			v = 4'd9 + ch[3:0];
		return v;
	endfunction

endpackage
`default_nettype wire

[hdl/rhcp_next.sv]
`default_nettype none
module rhcp_next (
	input  wire rhcp_pkg::lamp_state_t cur,
	input  wire logic [1:0]            op,
	input  wire logic [7:0]            data,
	input  wire logic                  button_pressed,
	output rhcp_pkg::lamp_state_t      nxt,
	output rhcp_pkg::lamp_flags_t      flags
);
	import rhcp_pkg::*;

	logic [3:0] digit;
	logic [7:0] hi_val;
	logic [7:0] lo_val;
	logic [7:0] addr_full;

	assign digit     = hex_value(data);
	assign hi_val    = {digit, 4'h0};
	assign lo_val    = {4'h0, digit};
	assign addr_full = cur.address_stage | lo_val;

	always_comb begin
		nxt   = cur;
		flags = '0;
		case (op)
			OP_BYTE: begin
				case (cur.parse_state)
					PS_SEARCH: begin
						if (data == CH_PREFIX)
							nxt.parse_state = PS_COMMAND;
					end
					PS_COMMAND: begin
						if (data == CH_WRITE)
							nxt.parse_state = PS_RED_H;
						else if (data == CH_ID && cur.prog_mode)
							nxt.parse_state = PS_STUFF_0;
						else
							nxt.parse_state = PS_SEARCH;
					end
					PS_RED_H: begin
						nxt.red_stage   = hi_val;
						nxt.parse_state = PS_RED_L;
					end
					PS_RED_L: begin
						nxt.red_stage   = cur.red_stage | lo_val;
						nxt.parse_state = PS_GREEN_H;
					end
					PS_GREEN_H: begin
						nxt.green_stage = hi_val;
						nxt.parse_state = PS_GREEN_L;
					end
					PS_GREEN_L: begin
						nxt.green_stage = cur.green_stage | lo_val;
						nxt.parse_state = PS_BLUE_H;
					end
					PS_BLUE_H: begin
						nxt.blue_stage  = hi_val;
						nxt.parse_state = PS_BLUE_L;
					end
					PS_BLUE_L: begin
						nxt.blue_stage  = cur.blue_stage | lo_val;
						nxt.parse_state = PS_ADDR_H;
					end
					PS_ADDR_H: begin
						nxt.address_stage = hi_val;
						nxt.parse_state   = PS_ADDR_L;
					end
					PS_ADDR_L: begin
						nxt.address_stage = addr_full;
						nxt.parse_state   = (addr_full == cur.own_address) ? PS_END_W : PS_SEARCH;
					end
					PS_END_W: begin
						if (data == CH_END) begin
							nxt.red_shown       = cur.red_stage;
							nxt.green_shown     = cur.green_stage;
							nxt.blue_shown      = cur.blue_stage;
							flags.colour_update = 1'b1;
						end
						nxt.parse_state = PS_SEARCH;
					end
					PS_STUFF_0: nxt.parse_state = PS_STUFF_1;
					PS_STUFF_1: nxt.parse_state = PS_STUFF_2;
					PS_STUFF_2: nxt.parse_state = PS_STUFF_3;
					PS_STUFF_3: nxt.parse_state = PS_TYPE_H;
					PS_TYPE_H:  nxt.parse_state = PS_TYPE_L;
					PS_TYPE_L:  nxt.parse_state = PS_NEW_H;
					PS_NEW_H: begin
						nxt.address_stage = hi_val;
						nxt.parse_state   = PS_NEW_L;
					end
					PS_NEW_L: begin
						nxt.address_stage = addr_full;
						nxt.parse_state   = PS_END_I;
					end
					PS_END_I: begin
						if (data == CH_END) begin
							nxt.own_address     = cur.address_stage;
							flags.addr_store    = 1'b1;
							nxt.red_shown       = '0;
							nxt.green_shown     = '0;
							nxt.blue_shown      = '0;
							flags.colour_update = 1'b1;
							nxt.prog_mode       = 1'b0;
						end
						nxt.parse_state = PS_SEARCH;
					end
					default: nxt.parse_state = PS_SEARCH;
				endcase
			end
			OP_TICK: begin
				case (cur.button_state)
					BT_RELEASED: begin
						if (button_pressed)
							nxt.button_state = BT_PRESS_SEEN;
					end
					BT_PRESS_SEEN: begin
						if (button_pressed) begin
							// toggle mode, white on entry and black on exit
							nxt.prog_mode       = !cur.prog_mode;
							nxt.red_shown       = cur.prog_mode ? 8'h00 : LEVEL_FULL;
							nxt.green_shown     = cur.prog_mode ? 8'h00 : LEVEL_FULL;
							nxt.blue_shown      = cur.prog_mode ? 8'h00 : LEVEL_FULL;
							flags.colour_update = 1'b1;
							nxt.button_state    = BT_PRESSED;
						end else begin
							nxt.button_state = BT_RELEASED;
						end
					end
					BT_PRESSED: begin
						if (!button_pressed)
							nxt.button_state = BT_RELEASE_SEEN;
					end
					default: begin
						nxt.button_state = button_pressed ? BT_PRESSED : BT_RELEASED;
					end
				endcase
			end
			OP_LOAD: nxt.own_address = data;
			default: nxt = cur;
		endcase
	end

endmodule
`default_nettype wire

[hdl/rgb_hex_command_parser_unit.sv]
`default_nettype none
// a request accepted at the input moves through the input register into the result register
// throughput: one request per cycle unless out_stall holds the result, set by the combinational
//   state update between the input register and the result register
// reset (arst_n low, asynchronous): parser searches for prefix, own address 255,
//   programming mode off, button released, shown colour red 128 green 50 blue 100
module rgb_hex_command_parser_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] op,
	input  wire logic [7:0] data,
	input  wire logic       button_pressed,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      red_level,
	output logic [7:0]      green_level,
	output logic [7:0]      blue_level,
	output logic            colour_update,
	output logic            addr_store,
	output logic [7:0]      own_address_out,
	output logic            programming
);
	import rhcp_pkg::*;

	// input register stage
	logic       valid_s1;
	logic [1:0] op_s1;
	logic [7:0] data_s1;
	logic       pressed_s1;

	// lamp state and result register
	lamp_state_t state_q;
	lamp_state_t state_next;
	lamp_flags_t flags_next;
	logic        out_valid_q;
	lamp_flags_t flags_q;

	logic res_free;   // result register can take a new request this cycle
	logic do_step;    // request in stage 1 moves into the result register
	logic in_take;

	assign res_free = !out_valid_q || !out_stall;
	assign do_step  = valid_s1 && res_free;
	// stage 1 holds while its request cannot move on
	assign in_stall = valid_s1 && !res_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of stage 1, loaded only with a fresh request
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1      <= op;
			data_s1    <= data;
			pressed_s1 <= button_pressed;
		end
	end

	// parser, debounce and colour update for one request
	rhcp_next u_next (
		.cur            (state_q),
		.op             (op_s1),
		.data           (data_s1),
		.button_pressed (pressed_s1),
		.nxt            (state_next),
		.flags          (flags_next)
	);

	// lamp state advances exactly when a request reaches the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.parse_state   <= PS_SEARCH;
			state_q.red_stage     <= '0;
			state_q.green_stage   <= '0;
			state_q.blue_stage    <= '0;
			state_q.address_stage <= '0;
			state_q.own_address   <= OWN_ADDR_RESET;
			state_q.prog_mode     <= 1'b0;
			state_q.button_state  <= BT_RELEASED;
			state_q.red_shown     <= RED_RESET;
			state_q.green_shown   <= GREEN_RESET;
			state_q.blue_shown    <= BLUE_RESET;
		end else if (do_step) begin
			state_q <= state_next;
		end
	end

	// result valid: set by a finished request, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// per-request flags live with the result
	always_ff @(posedge clk) begin
		if (do_step) begin
			flags_q <= flags_next;
		end
	end

	// the result shows the state left by its request, which the state
	// registers keep until the next request is stepped
	assign out_valid       = out_valid_q;
	assign red_level       = state_q.red_shown;
	assign green_level     = state_q.green_shown;
	assign blue_level      = state_q.blue_shown;
	assign colour_update   = flags_q.colour_update;
	assign addr_store      = flags_q.addr_store;
	assign own_address_out = state_q.own_address;
	assign programming     = state_q.prog_mode;

endmodule
`default_nettype wire
